// ----- src/swm_pkg.sv -----
// shared types and constants for the sliding window median filter
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int MEDIAN_W       = 33;
  localparam int CFG_W          = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } swm_in_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_doubled;
  } swm_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_size;
  } swm_cfg_t;

  typedef struct packed {
    logic load;
    logic evicting;
    logic valid;
  } swm_cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/swm_stream_if.sv -----
// valid/ready channel carrying one item of a given payload type
`default_nettype none

interface swm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/swm_cell.sv -----
// one cell of the sorted chain: holds a value and its age, evicts and inserts
`default_nettype none

module swm_cell #(
  parameter int AW = 6
) (
  input  wire                             clk_i,
  input  wire swm_pkg::swm_cell_ctl_t     ctl_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] evict_val_i,
  input  wire logic [AW-1:0]              oldest_age_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] r_val_i,
  input  wire logic [AW-1:0]              r_age_i,
  input  wire logic                       r_gt_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] l_val_i,
  input  wire logic [AW-1:0]              l_age_i,
  input  wire logic                       l_gt_i,
  output logic signed [swm_pkg::SAMPLE_W-1:0] val_o,
  output logic [AW-1:0]                   age_o,
  output logic                            gt_o,
  output logic                            evict_o,
  output logic signed [swm_pkg::SAMPLE_W-1:0] b_val_o,
  output logic [AW-1:0]                   b_age_o,
  output logic                            b_gt_o
);

  logic signed [swm_pkg::SAMPLE_W-1:0] val_q, val_d;
  logic [AW-1:0]                       age_q, age_d;
  logic                                evict, left, shl;

  always_comb begin
    evict = ctl_i.valid && ctl_i.evicting && (age_q == oldest_age_i);
    // evicted cell sits left of this one
    left  = ctl_i.valid && ctl_i.evicting && !evict && (val_q >= evict_val_i);
    shl   = evict || left;
    gt_o  = !ctl_i.valid || (val_q > sample_i);

    b_val_o = shl ? r_val_i : val_q;
    b_age_o = shl ? r_age_i : age_q;
    b_gt_o  = shl ? r_gt_i  : gt_o;

    if (l_gt_i) begin
      val_d = l_val_i;
      age_d = l_age_i + 1'b1;
    end else if (b_gt_o) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = b_val_o;
      age_d = b_age_o + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o   = val_q;
  assign age_o   = age_q;
  assign evict_o = evict;

endmodule

`default_nettype wire

// ----- src/swm_median.sv -----
// picks the middle cells and registers twice the median
`default_nettype none

module swm_median #(
  parameter int N  = 64,
  parameter int CW = 7,
  parameter int IW = 6
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire logic                move_i,
  input  wire logic [CW-1:0]       win_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] vals_i [N],
  swm_stream_if.source             med_o
);

  logic [IW-1:0]                       mid, lo;
  logic signed [swm_pkg::SAMPLE_W-1:0] a, b;
  logic signed [swm_pkg::MEDIAN_W-1:0] sum;
  logic                                valid_q;
  swm_pkg::swm_out_t                   data_q;

  always_comb begin
    mid = IW'(win_i >> 1);
    lo  = win_i[0] ? mid : IW'(mid - 1'b1);
    a   = vals_i[mid];
    b   = vals_i[lo];
    sum = {a[swm_pkg::SAMPLE_W-1], a} + {b[swm_pkg::SAMPLE_W-1], b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (move_i) begin
      valid_q <= 1'b1;
    end else if (med_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_i) begin
      data_q.median_doubled <= sum;
    end
  end

  assign med_o.valid = valid_q;
  assign med_o.data  = data_q;

endmodule

`default_nettype wire

// ----- src/sliding_window_median.sv -----
// Running median over the last window_size signed samples. One item is taken per clock while
// the output is not stalled: a chain of MAX_WINDOW cells keeps the window sorted, and in the
// cycle an item is accepted every cell compares itself with the new sample and the evicted
// value and shifts left, right or takes the sample, so the cost of an item is one pass through
// the cell chain. An accepted item that fills the window sets a pending flag, and the result
// register loads median_doubled while that flag is set and the output is free. No result comes
// out while the window is filling. A restart or a write of window_size empties the window;
// window_size 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
`default_nettype none

module sliding_window_median #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  swm_stream_if.sink   smp_i,
  swm_stream_if.sink   cfg_i,
  swm_stream_if.source med_o
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int XW = (CW > swm_pkg::CFG_W) ? CW : swm_pkg::CFG_W;

  logic [swm_pkg::CFG_W-1:0] win_cfg_q;
  logic [CW-1:0]             fill_q, fill_d;
  logic                      pend_q, pend_d;

  logic [XW-1:0]             win_x;
  logic [CW-1:0]             win, fill_eff;
  logic [IW-1:0]             oldest;
  logic                      evicting, acc, move;

  logic signed [swm_pkg::SAMPLE_W-1:0] val   [MAX_WINDOW];
  logic [IW-1:0]                       age   [MAX_WINDOW];
  logic                                gt    [MAX_WINDOW];
  logic                                evict [MAX_WINDOW];
  logic signed [swm_pkg::SAMPLE_W-1:0] b_val [MAX_WINDOW];
  logic [IW-1:0]                       b_age [MAX_WINDOW];
  logic                                b_gt  [MAX_WINDOW];
  logic signed [swm_pkg::SAMPLE_W-1:0] evict_val;

  always_comb begin
    win_x = XW'(win_cfg_q);
    if (win_x == '0) begin
      win_x = XW'(1);
    end else if (win_x > XW'(MAX_WINDOW)) begin
      win_x = XW'(MAX_WINDOW);
    end
    win    = win_x[CW-1:0];
    oldest = IW'(win - 1'b1);

    fill_eff = (smp_i.data.restart || (fill_q > win)) ? '0 : fill_q;
    evicting = (fill_eff == win);
    fill_d   = evicting ? fill_eff : CW'(fill_eff + 1'b1);

    move = pend_q && (!med_o.valid || med_o.ready);
    acc  = smp_i.valid && smp_i.ready;
    pend_d = (pend_q && !move) || (acc && (fill_d == win));

    evict_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      evict_val = evict_val | (evict[i] ? val[i] : '0);
    end
  end

  assign smp_i.ready = !pend_q || move;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= swm_pkg::WINDOW_RESET;
      fill_q    <= '0;
      pend_q    <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (cfg_i.valid) begin
        win_cfg_q <= cfg_i.data.window_size;
        fill_q    <= '0;
      end else if (acc) begin
        fill_q <= fill_d;
      end
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_pkg::swm_cell_ctl_t              ctl;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_val, l_val;
    logic [IW-1:0]                       r_age, l_age;
    logic                                r_gt, l_gt;

    always_comb begin
      ctl.load     = acc;
      ctl.evicting = evicting;
      ctl.valid    = (CW'(i) < fill_eff);
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign r_val = '0;
      assign r_age = '0;
      assign r_gt  = 1'b1;
    end else begin : g_mid
      assign r_val = val[i+1];
      assign r_age = age[i+1];
      assign r_gt  = gt[i+1];
    end

    if (i == 0) begin : g_first
      assign l_val = '0;
      assign l_age = '0;
      assign l_gt  = 1'b0;
    end else begin : g_rest
      assign l_val = b_val[i-1];
      assign l_age = b_age[i-1];
      assign l_gt  = b_gt[i-1];
    end

    swm_cell #(.AW(IW)) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .sample_i     (smp_i.data.sample),
      .evict_val_i  (evict_val),
      .oldest_age_i (oldest),
      .r_val_i      (r_val),
      .r_age_i      (r_age),
      .r_gt_i       (r_gt),
      .l_val_i      (l_val),
      .l_age_i      (l_age),
      .l_gt_i       (l_gt),
      .val_o        (val[i]),
      .age_o        (age[i]),
      .gt_o         (gt[i]),
      .evict_o      (evict[i]),
      .b_val_o      (b_val[i]),
      .b_age_o      (b_age[i]),
      .b_gt_o       (b_gt[i])
    );
  end

  swm_median #(.N(MAX_WINDOW), .CW(CW), .IW(IW)) u_median (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .move_i (move),
    .win_i  (win),
    .vals_i (val),
    .med_o  (med_o)
  );

endmodule

`default_nettype wire

// ----- src/swm_checker.sv -----
// port-level checks for the sliding window median filter
`default_nettype none

module swm_checker #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire logic                          smp_valid_i,
  input wire logic                          smp_ready_i,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_i,
  input wire logic [swm_pkg::CFG_W-1:0]     cfg_data_i,
  input wire logic                          med_valid_i,
  input wire logic                          med_ready_i,
  input wire logic [swm_pkg::MEDIAN_W-1:0]  med_data_i
);

  logic [swm_pkg::CFG_W-1:0] win_q;
  logic                      seen_q;
  logic                      win_odd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= swm_pkg::WINDOW_RESET;
      seen_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      win_q  <= cfg_data_i;
      seen_q <= 1'b0;
    end else if (smp_valid_i && smp_ready_i) begin
      seen_q <= 1'b1;
    end
  end

  always_comb begin
    if (win_q == '0) begin
      win_odd = 1'b1;
    end else if (32'(win_q) > MAX_WINDOW) begin
      win_odd = (MAX_WINDOW % 2) == 1;
    end else begin
      win_odd = win_q[0];
    end
  end

  a_med_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_valid_i && !med_ready_i |=> med_valid_i && $stable(med_data_i))
    else $error("result dropped or changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_valid_i |-> seen_q)
    else $error("result without a sample since reset or window change");

  a_odd_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_valid_i && win_odd |-> !med_data_i[0])
    else $error("odd window gave an odd doubled median");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !med_valid_i |-> smp_ready_i)
    else $error("input stalled while output register is empty");

endmodule

bind sliding_window_median swm_checker #(.MAX_WINDOW(MAX_WINDOW)) u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .smp_valid_i (smp_i.valid),
  .smp_ready_i (smp_i.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_data_i  (cfg_i.data.window_size),
  .med_valid_i (med_o.valid),
  .med_ready_i (med_o.ready),
  .med_data_i  (med_o.data.median_doubled)
);

`default_nettype wire

// ----- verif/tb.sv -----
// testbench for the sliding window median filter with randomized stream and window settings
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              smp_valid = 1'b0;
  swm_pkg::swm_in_t  smp_data = '0;
  logic              cfg_valid = 1'b0;
  swm_pkg::swm_cfg_t cfg_data = '0;
  logic              med_ready = 1'b0;
  bit                steady = 1'b0;
  int                errors = 0;

  swm_stream_if #(.T(swm_pkg::swm_in_t))  smp_if ();
  swm_stream_if #(.T(swm_pkg::swm_cfg_t)) cfg_if ();
  swm_stream_if #(.T(swm_pkg::swm_out_t)) med_if ();

  assign smp_if.valid = smp_valid;
  assign smp_if.data  = smp_data;
  assign cfg_if.valid = cfg_valid;
  assign cfg_if.data  = cfg_data;
  assign med_if.ready = med_ready;

  sliding_window_median u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .smp_i  (smp_if),
    .cfg_i  (cfg_if),
    .med_o  (med_if)
  );

  always #5 clk = ~clk;

  swm_pkg::swm_in_t                    sample_q [$];
  logic signed [swm_pkg::MEDIAN_W-1:0] median_q [$];

  // sorted window kept alongside the block
  logic signed [swm_pkg::SAMPLE_W-1:0] win_vals [swm_pkg::MAX_WINDOW_DEF];
  int                                  win_ages [swm_pkg::MAX_WINDOW_DEF];
  int                                  win_fill = 0;
  logic [swm_pkg::CFG_W-1:0]           win_size_reg = swm_pkg::WINDOW_RESET;

  function automatic void median_window_step(input logic signed [swm_pkg::SAMPLE_W-1:0] s,
                                             input logic new_seq, output bit produced,
                                             output logic signed [swm_pkg::MEDIAN_W-1:0] med);
    int w;
    int pos;
    logic signed [swm_pkg::MEDIAN_W-1:0] lo;
    logic signed [swm_pkg::MEDIAN_W-1:0] hi;
    w = int'(win_size_reg);
    if (w < 1) w = 1;
    if (w > swm_pkg::MAX_WINDOW_DEF) w = swm_pkg::MAX_WINDOW_DEF;
    if (new_seq) win_fill = 0;
    if (win_fill > w) win_fill = 0;
    if (win_fill == w) begin
      pos = 0;
      for (int i = 0; i < win_fill; i++) begin
        if (win_ages[i] == w - 1) begin
          pos = i;
          break;
        end
      end
      for (int i = pos; i + 1 < win_fill; i++) begin
        win_vals[i] = win_vals[i + 1];
        win_ages[i] = win_ages[i + 1];
      end
      win_fill--;
    end
    for (int i = 0; i < win_fill; i++) win_ages[i]++;
    pos = win_fill;
    for (int i = 0; i < win_fill; i++) begin
      if (win_vals[i] > s) begin
        pos = i;
        break;
      end
    end
    for (int i = win_fill; i > pos; i--) begin
      win_vals[i] = win_vals[i - 1];
      win_ages[i] = win_ages[i - 1];
    end
    win_vals[pos] = s;
    win_ages[pos] = 0;
    win_fill++;
    produced = (win_fill == w);
    med = '0;
    if (produced) begin
      if (w % 2 == 1) begin
        lo = {win_vals[w / 2][swm_pkg::SAMPLE_W-1], win_vals[w / 2]};
        med = lo + lo;
      end else begin
        lo = {win_vals[w / 2 - 1][swm_pkg::SAMPLE_W-1], win_vals[w / 2 - 1]};
        hi = {win_vals[w / 2][swm_pkg::SAMPLE_W-1], win_vals[w / 2]};
        med = lo + hi;
      end
    end
  endfunction

  function automatic void add_item(input logic signed [swm_pkg::SAMPLE_W-1:0] s,
                                   input logic r);
    swm_pkg::swm_in_t it;
    it.sample  = s;
    it.restart = r;
    sample_q = {sample_q, it};
  endfunction

  function automatic swm_pkg::swm_in_t rand_item(input int restart_per_mille);
    swm_pkg::swm_in_t it;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: it.sample = $urandom;
      5, 6:          it.sample = $signed($urandom_range(16)) - 8;
      7: begin
        case ($urandom_range(3))
          0:       it.sample = 32'sh7fffffff;
          1:       it.sample = 32'sh80000000;
          2:       it.sample = '0;
          default: it.sample = '1;
        endcase
      end
      8:       it.sample = 32'sh7fffffff - $signed($urandom_range(3));
      default: it.sample = 32'sh80000000 + $signed($urandom_range(3));
    endcase
    it.restart = ($urandom_range(999) < restart_per_mille);
    return it;
  endfunction

  // sample driver
  always @(posedge clk) begin
    bit produced;
    logic signed [swm_pkg::MEDIAN_W-1:0] med;
    swm_pkg::swm_in_t nxt;
    if (rst_n) begin
      if (smp_valid && smp_if.ready) begin
        median_window_step(smp_data.sample, smp_data.restart, produced, med);
        if (produced) median_q = {median_q, med};
      end
      if (!smp_valid || smp_if.ready) begin
        if (sample_q.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
          nxt = sample_q.pop_front();
          smp_data  <= nxt;
          smp_valid <= 1'b1;
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // median monitor
  always @(posedge clk) begin
    logic signed [swm_pkg::MEDIAN_W-1:0] want;
    if (rst_n) begin
      if (med_if.valid && med_ready) begin
        if (median_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected median %0d", med_if.data.median_doubled);
        end else begin
          want = median_q.pop_front();
          if (med_if.data.median_doubled !== want) begin
            errors++;
            if (errors <= 10)
              $display("median_doubled mismatch: expected %0d, got %0d", want,
                       med_if.data.median_doubled);
          end
        end
      end
      med_ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || smp_valid || median_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] w);
    @(posedge clk);
    cfg_data.window_size <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    win_size_reg = w;
    win_fill = 0;
  endtask

  initial begin
    int windows [11] = '{1, 0, 64, 127, 2, 5, 63, 4, 8, 6, 0};
    int restarts [11] = '{20, 20, 3, 3, 30, 150, 3, 10, 10, 400, 10};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset window of three: extremes, ties and restarts
    add_item(32'sh7fffffff, 1'b0);
    add_item(32'sh80000000, 1'b0);
    add_item(32'sh80000000, 1'b0);
    add_item(32'sh7fffffff, 1'b0);
    add_item(32'sh7fffffff, 1'b0);
    add_item('0, 1'b0);
    add_item('1, 1'b0);
    add_item('1, 1'b0);
    add_item(32'sd5, 1'b1);
    add_item(32'sd5, 1'b0);
    add_item(32'sd5, 1'b0);
    add_item(-32'sd7, 1'b0);
    add_item(32'sd3, 1'b1);
    add_item(32'sd2, 1'b0);
    wait_drained();

    // even window: sums at both extremes
    write_window(7'd2);
    add_item(32'sh7fffffff, 1'b0);
    add_item(32'sh7fffffff, 1'b0);
    add_item(32'sh80000000, 1'b0);
    add_item(32'sh80000000, 1'b0);
    add_item(32'sh7fffffff, 1'b0);
    add_item('1, 1'b0);
    add_item('0, 1'b1);
    add_item(32'sd1, 1'b0);
    wait_drained();

    windows[10] = $urandom_range(127);
    for (int p = 0; p < 11; p++) begin
      write_window(windows[p][swm_pkg::CFG_W-1:0]);
      steady = (p == 2);
      for (int k = 0; k < 170; k++) sample_q = {sample_q, rand_item(restarts[p])};
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    errors += median_q.size();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
